// File: rtl/plb_pkg.sv
// Shared types, codes and entry arithmetic for the per-CPU load balancer.
package plb_pkg;

  localparam logic [31:0] LOAD_MAX = 32'hFFFF_FFFF;
  localparam logic [15:0] CNT_MAX  = 16'hFFFF;
  localparam logic [15:0] ONE_UNIT = 16'd1;

  typedef enum logic [1:0] {
    K_ADD    = 2'd0,
    K_REMOVE = 2'd1,
    K_SET    = 2'd2,
    K_TICK   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CFG_CPUS_PRESENT   = 2'd0,
    CFG_BAL_INTERVAL   = 2'd1,
    CFG_IMB_THRESHOLD  = 2'd2,
    CFG_MIGRATE_ENABLE = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FETCH,
    S_MOD,
    S_BAL,
    S_MV_RD,
    S_MV_WR1,
    S_MV_WR2,
    S_SUM,
    S_DONE
  } state_t;

  // One table entry per CPU
  typedef struct packed {
    logic        running;
    logic [31:0] last_balance;
    logic [31:0] load;
    logic [15:0] cnt;
  } entry_t;

  typedef struct packed {
    logic [31:0] tick_now;
    logic        running_flag;
    logic [15:0] load_amount;
    logic [2:0]  cpu_index;
    kind_t       kind;
  } item_t;

  typedef struct packed {
    logic        migration_enable;
    logic [15:0] imbalance_threshold;
    logic [15:0] balance_interval;
    logic [3:0]  cpus_present;
  } cfg_t;

  typedef struct packed {
    logic [31:0] load_sum;
    logic        idlest_valid;
    logic [2:0]  least_cpu;
    logic [2:0]  to_cpu;
    logic [2:0]  from_cpu;
    logic        migrated;
  } result_t;

  // count +1 and load +amt, both saturating
  function automatic entry_t ent_up(entry_t e, logic [15:0] amt);
    logic [32:0] s;
    entry_t      r;
    r = e;
    if (e.cnt != CNT_MAX) begin
      r.cnt = e.cnt + 16'd1;
    end
    s = {1'b0, e.load} + {17'b0, amt};
    r.load = s[32] ? LOAD_MAX : s[31:0];
    return r;
  endfunction

  // count -1 and load -amt, both floored at zero
  function automatic entry_t ent_down(entry_t e, logic [15:0] amt);
    entry_t r;
    r = e;
    r.cnt  = (e.cnt != 16'd0) ? e.cnt - 16'd1 : 16'd0;
    r.load = (e.load >= {16'b0, amt}) ? e.load - {16'b0, amt} : 32'd0;
    return r;
  endfunction

endpackage

// File: rtl/per_cpu_load_balancer.sv
// Top level of the per-CPU load balancer: ports, configuration registers, result register.
//
// Per-CPU load balancer. A table of MAX_CPU_SLOTS entries (runnable count, load,
// last balance tick, running flag) sits in a single-port-read, single-port-write
// memory, and every item is handled one at a time by a read-modify-write sequencer
// followed by a scan over the n present CPUs; a tick that balances runs a balance
// scan, and a migration if one is due, before that summary scan. An item whose CPU
// index lies beyond the table skips the read-modify-write. The memory gives the
// scans one entry per cycle. A finished result sits in the output register, so the
// next item is accepted while it waits. Configuration must be written through
// cfg_we, cfg_index and cfg_wdata only while no item is in flight; the user is
// bound by this, and the block itself does not enforce it.
module per_cpu_load_balancer #(
  parameter int MAX_CPU_SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // cpu_index[2:0], load_amount[18:3], running_flag[19],
                                  // tick_now[51:20], zero fill
  input  logic [1:0]  in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // migrated[0], from_cpu[3:1], to_cpu[6:4],
                                  // least_cpu[9:7], idlest_valid[10], load_sum[42:11], zero fill
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int IDX_W = $clog2(MAX_CPU_SLOTS);

  plb_pkg::cfg_t    cfg_r;
  plb_pkg::item_t   item;
  plb_pkg::result_t res;
  logic             res_vld;
  logic             res_rdy;
  logic             out_tvalid_r;
  logic [47:0]      out_tdata_r;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  plb_pkg::entry_t  wr_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  plb_pkg::entry_t  rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cpus_present        <= 4'd1;
      cfg_r.balance_interval    <= 16'd100;
      cfg_r.imbalance_threshold <= 16'd2;
      cfg_r.migration_enable    <= 1'b1;
    end else if (cfg_we) begin
      unique case (plb_pkg::cfg_idx_t'(cfg_index))
        plb_pkg::CFG_CPUS_PRESENT:   cfg_r.cpus_present        <= cfg_wdata[3:0];
        plb_pkg::CFG_BAL_INTERVAL:   cfg_r.balance_interval    <= cfg_wdata;
        plb_pkg::CFG_IMB_THRESHOLD:  cfg_r.imbalance_threshold <= cfg_wdata;
        plb_pkg::CFG_MIGRATE_ENABLE: cfg_r.migration_enable    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign item.kind         = plb_pkg::kind_t'(in_tuser);
  assign item.cpu_index    = in_tdata[2:0];
  assign item.load_amount  = in_tdata[18:3];
  assign item.running_flag = in_tdata[19];
  assign item.tick_now     = in_tdata[51:20];

  plb_table #(
    .MAX_CPU_SLOTS(MAX_CPU_SLOTS)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  plb_ctrl #(
    .MAX_CPU_SLOTS(MAX_CPU_SLOTS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (item),
    .cfg      (cfg_r),
    .res_vld  (res_vld),
    .res_rdy  (res_rdy),
    .res      (res),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data)
  );

  // output slot frees when empty or being taken
  assign res_rdy = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_vld && res_rdy) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld && res_rdy) begin
      out_tdata_r <= {5'b0, res.load_sum, res.idlest_valid, res.least_cpu,
                      res.to_cpu, res.from_cpu, res.migrated};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// File: rtl/plb_table.sv
// Per-CPU table memory: one write port, one registered read port, reset valid bits.
module plb_table #(
  parameter int MAX_CPU_SLOTS = 8,
  localparam int IDX_W = $clog2(MAX_CPU_SLOTS)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_addr,
  input  plb_pkg::entry_t      wr_data,
  input  logic                 rd_en,
  input  logic [IDX_W-1:0]     rd_addr,
  output plb_pkg::entry_t      rd_data
);

  plb_pkg::entry_t            mem [MAX_CPU_SLOTS];
  logic [MAX_CPU_SLOTS-1:0]   vld_r;
  plb_pkg::entry_t            rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // same-cycle write to the read address is forwarded
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else if (vld_r[rd_addr]) begin
        rd_data_r <= mem[rd_addr];
      end else begin
        rd_data_r <= '0;
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/plb_ctrl.sv
// Sequencer: read-modify-write of the target entry, balance scan, migration, summary scan.
module plb_ctrl #(
  parameter int MAX_CPU_SLOTS = 8,
  localparam int IDX_W = $clog2(MAX_CPU_SLOTS),
  localparam int CNT_W = $clog2(MAX_CPU_SLOTS + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  plb_pkg::item_t       in_item,
  input  plb_pkg::cfg_t        cfg,
  output logic                 res_vld,
  input  logic                 res_rdy,
  output plb_pkg::result_t     res,
  output logic                 wr_en,
  output logic [IDX_W-1:0]     wr_addr,
  output plb_pkg::entry_t      wr_data,
  output logic                 rd_en,
  output logic [IDX_W-1:0]     rd_addr,
  input  plb_pkg::entry_t      rd_data
);

  plb_pkg::state_t state_r, state_nxt;
  plb_pkg::item_t  item_r, item_nxt;

  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             proc_vld_r, proc_vld_nxt;
  logic [IDX_W-1:0] proc_idx_r, proc_idx_nxt;

  logic [15:0]      max_cnt_r, max_cnt_nxt;
  logic [15:0]      min_cnt_r, min_cnt_nxt;
  logic [IDX_W-1:0] busy_idx_r, busy_idx_nxt;
  logic [IDX_W-1:0] idle_idx_r, idle_idx_nxt;
  logic             moved_r, moved_nxt;

  logic [31:0]      sum_r, sum_nxt;
  logic [IDX_W-1:0] idl_r, idl_nxt;
  logic             idl_vld_r, idl_vld_nxt;
  logic [15:0]      idl_cnt_r, idl_cnt_nxt;

  logic [CNT_W-1:0] n_cpus;
  logic [IDX_W-1:0] me_addr;
  logic             in_idx_ok;
  logic             scan_issue;
  logic             scan_done;
  logic             tick_pass;
  logic             migrate_go;
  logic             start_scan;
  logic [31:0]      since_last;
  logic [32:0]      sum_add;

  // CPUs taking part: register value capped at the table depth
  assign n_cpus = (32'(cfg.cpus_present) > 32'(MAX_CPU_SLOTS)) ?
                  CNT_W'(MAX_CPU_SLOTS) : CNT_W'(cfg.cpus_present);

  assign in_idx_ok  = 32'(in_item.cpu_index) < 32'(MAX_CPU_SLOTS);
  assign me_addr    = IDX_W'(item_r.cpu_index);
  assign scan_issue = rd_idx_r < n_cpus;
  assign scan_done  = !scan_issue && !proc_vld_r;
  assign since_last = item_r.tick_now - rd_data.last_balance;
  assign tick_pass  = (n_cpus > CNT_W'(1)) && (since_last >= {16'b0, cfg.balance_interval});
  assign migrate_go = ((max_cnt_r - min_cnt_r) > cfg.imbalance_threshold) &&
                      cfg.migration_enable;
  assign sum_add    = {1'b0, sum_r} + {1'b0, rd_data.load};
  assign start_scan = (state_nxt != state_r) &&
                      ((state_nxt == plb_pkg::S_BAL) || (state_nxt == plb_pkg::S_SUM));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      plb_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = in_idx_ok ? plb_pkg::S_FETCH : plb_pkg::S_SUM;
        end
      end
      plb_pkg::S_FETCH: state_nxt = plb_pkg::S_MOD;
      plb_pkg::S_MOD: begin
        if ((item_r.kind == plb_pkg::K_TICK) && tick_pass) begin
          state_nxt = plb_pkg::S_BAL;
        end else begin
          state_nxt = plb_pkg::S_SUM;
        end
      end
      plb_pkg::S_BAL: begin
        if (scan_done) begin
          state_nxt = migrate_go ? plb_pkg::S_MV_RD : plb_pkg::S_SUM;
        end
      end
      plb_pkg::S_MV_RD:  state_nxt = plb_pkg::S_MV_WR1;
      plb_pkg::S_MV_WR1: state_nxt = plb_pkg::S_MV_WR2;
      plb_pkg::S_MV_WR2: state_nxt = plb_pkg::S_SUM;
      plb_pkg::S_SUM: begin
        if (scan_done) begin
          state_nxt = plb_pkg::S_DONE;
        end
      end
      plb_pkg::S_DONE: begin
        if (res_rdy) begin
          state_nxt = plb_pkg::S_IDLE;
        end
      end
      default: state_nxt = plb_pkg::S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    in_ready     = 1'b0;
    res_vld      = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = me_addr;
    wr_en        = 1'b0;
    wr_addr      = me_addr;
    wr_data      = rd_data;
    item_nxt     = item_r;
    rd_idx_nxt   = rd_idx_r;
    proc_vld_nxt = 1'b0;
    proc_idx_nxt = proc_idx_r;
    max_cnt_nxt  = max_cnt_r;
    min_cnt_nxt  = min_cnt_r;
    busy_idx_nxt = busy_idx_r;
    idle_idx_nxt = idle_idx_r;
    moved_nxt    = moved_r;
    sum_nxt      = sum_r;
    idl_nxt      = idl_r;
    idl_vld_nxt  = idl_vld_r;
    idl_cnt_nxt  = idl_cnt_r;

    unique case (state_r)
      plb_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          item_nxt  = in_item;
          moved_nxt = 1'b0;
        end
      end
      plb_pkg::S_FETCH: begin
        rd_en = 1'b1;
      end
      plb_pkg::S_MOD: begin
        case (item_r.kind)
          plb_pkg::K_ADD: begin
            wr_en   = 1'b1;
            wr_data = plb_pkg::ent_up(rd_data, item_r.load_amount);
          end
          plb_pkg::K_REMOVE: begin
            wr_en   = 1'b1;
            wr_data = plb_pkg::ent_down(rd_data, item_r.load_amount);
          end
          plb_pkg::K_SET: begin
            wr_en           = 1'b1;
            wr_data.running = item_r.running_flag;
          end
          default: begin
            wr_en                = tick_pass;
            wr_data.last_balance = item_r.tick_now;
          end
        endcase
        // the ticking CPU seeds both searches
        max_cnt_nxt  = rd_data.cnt;
        min_cnt_nxt  = rd_data.cnt;
        busy_idx_nxt = me_addr;
        idle_idx_nxt = me_addr;
      end
      plb_pkg::S_BAL, plb_pkg::S_SUM: begin
        rd_en        = scan_issue;
        rd_addr      = IDX_W'(rd_idx_r);
        proc_vld_nxt = scan_issue;
        proc_idx_nxt = IDX_W'(rd_idx_r);
        if (scan_issue) begin
          rd_idx_nxt = rd_idx_r + CNT_W'(1);
        end
        if (proc_vld_r) begin
          if (state_r == plb_pkg::S_BAL) begin
            if (rd_data.running) begin
              if (rd_data.cnt > max_cnt_r) begin
                max_cnt_nxt  = rd_data.cnt;
                busy_idx_nxt = proc_idx_r;
              end
              if (rd_data.cnt < min_cnt_r) begin
                min_cnt_nxt  = rd_data.cnt;
                idle_idx_nxt = proc_idx_r;
              end
            end
          end else begin
            sum_nxt = sum_add[32] ? plb_pkg::LOAD_MAX : sum_add[31:0];
            if (rd_data.running && (!idl_vld_r || (rd_data.cnt < idl_cnt_r))) begin
              idl_nxt     = proc_idx_r;
              idl_cnt_nxt = rd_data.cnt;
              idl_vld_nxt = 1'b1;
            end
          end
        end
      end
      plb_pkg::S_MV_RD: begin
        rd_en   = 1'b1;
        rd_addr = busy_idx_r;
      end
      plb_pkg::S_MV_WR1: begin
        wr_en     = 1'b1;
        wr_addr   = busy_idx_r;
        wr_data   = plb_pkg::ent_down(rd_data, plb_pkg::ONE_UNIT);
        rd_en     = 1'b1;
        rd_addr   = idle_idx_r;
        moved_nxt = 1'b1;
      end
      plb_pkg::S_MV_WR2: begin
        wr_en   = 1'b1;
        wr_addr = idle_idx_r;
        wr_data = plb_pkg::ent_up(rd_data, plb_pkg::ONE_UNIT);
      end
      plb_pkg::S_DONE: begin
        res_vld = 1'b1;
      end
      default: ;
    endcase

    if (start_scan) begin
      rd_idx_nxt   = '0;
      proc_vld_nxt = 1'b0;
      if (state_nxt == plb_pkg::S_SUM) begin
        sum_nxt     = '0;
        idl_nxt     = '0;
        idl_vld_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= plb_pkg::S_IDLE;
      proc_vld_r <= 1'b0;
      rd_idx_r   <= '0;
      moved_r    <= 1'b0;
      idl_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      proc_vld_r <= proc_vld_nxt;
      rd_idx_r   <= rd_idx_nxt;
      moved_r    <= moved_nxt;
      idl_vld_r  <= idl_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    proc_idx_r <= proc_idx_nxt;
    max_cnt_r  <= max_cnt_nxt;
    min_cnt_r  <= min_cnt_nxt;
    busy_idx_r <= busy_idx_nxt;
    idle_idx_r <= idle_idx_nxt;
    sum_r      <= sum_nxt;
    idl_r      <= idl_nxt;
    idl_cnt_r  <= idl_cnt_nxt;
  end

  assign res.migrated     = moved_r;
  assign res.from_cpu     = moved_r ? 3'(busy_idx_r) : 3'd0;
  assign res.to_cpu       = moved_r ? 3'(idle_idx_r) : 3'd0;
  assign res.least_cpu    = idl_vld_r ? 3'(idl_r) : 3'd0;
  assign res.idlest_valid = idl_vld_r;
  assign res.load_sum     = sum_r;

`ifndef SYNTHESIS
  a_bal_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == plb_pkg::S_BAL) |-> (max_cnt_r >= min_cnt_r))
    else $error("busiest count below idlest count during balance scan");

  a_mv_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == plb_pkg::S_MV_WR1) |-> (busy_idx_r != idle_idx_r))
    else $error("migration source equals destination");

  a_proc_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    proc_vld_r |-> ((state_r == plb_pkg::S_BAL) || (state_r == plb_pkg::S_SUM)))
    else $error("scan read in flight outside a scan");

  a_mv_marked: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == plb_pkg::S_MV_WR2) |-> moved_r)
    else $error("migration write without migrated flag");
`endif

endmodule

// File: verif/per_cpu_load_balancer_tb.sv
// Self-checking stream testbench for the per-CPU load balancer: directed table, random phases.
module per_cpu_load_balancer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS       = 8;
  localparam int QUIET_LIMIT = 2000;
  localparam int SHOW_MAX    = 10;
  localparam int RAND_PHASES = 7;
  localparam int PHASE_ITEMS = 104;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;   // cpu_index, load_amount, running_flag, tick_now, zero fill
  logic [1:0]  in_tuser;   // kind
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // migrated, from_cpu, to_cpu, least_cpu, idlest_valid,
                           // load_sum, zero fill
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;

  per_cpu_load_balancer #(.MAX_CPU_SLOTS(SLOTS)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Predicted copy of the CPU table and the registers
  logic [15:0] tbl_cnt  [SLOTS];
  logic [31:0] tbl_load [SLOTS];
  logic [31:0] tbl_last [SLOTS];
  logic        tbl_run  [SLOTS];
  logic [3:0]  m_cpus;
  logic [15:0] m_ival;
  logic [15:0] m_thr;
  logic        m_mig;

  plb_pkg::result_t pending_res[$];
  int               fails;
  int               shown;
  int               quiet;
  bit               no_idle;

  typedef struct {
    bit               is_cfg;
    logic [1:0]       ridx;
    logic [15:0]      rval;
    logic [1:0]       k;
    logic [2:0]       c;
    logic [15:0]      amt;
    logic             flg;
    logic [31:0]      now;
    bit               typed;
    plb_pkg::result_t want;
  } step_t;

  step_t plan[$];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned cpus_taking_part();
    return (m_cpus > SLOTS) ? SLOTS : m_cpus;
  endfunction

  function automatic void entry_up(int unsigned c, logic [31:0] amt);
    logic [32:0] s;
    if (tbl_cnt[c] != 16'hFFFF) tbl_cnt[c] = tbl_cnt[c] + 16'd1;
    s = {1'b0, tbl_load[c]} + {1'b0, amt};
    tbl_load[c] = s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic void entry_down(int unsigned c, logic [31:0] amt);
    if (tbl_cnt[c] != 16'd0) tbl_cnt[c] = tbl_cnt[c] - 16'd1;
    tbl_load[c] = (tbl_load[c] >= amt) ? tbl_load[c] - amt : 32'd0;
  endfunction

  function automatic plb_pkg::result_t predict_item(plb_pkg::kind_t k, logic [2:0] c,
                                                    logic [15:0] amt, logic flg,
                                                    logic [31:0] now);
    plb_pkg::result_t r;
    int unsigned      n, busy, idle, i;
    logic [15:0]      hi, lo;
    logic [31:0]      sum, minc, d;
    logic [32:0]      s;
    r = '0;
    n = cpus_taking_part();
    case (k)
      plb_pkg::K_ADD:    entry_up(c, {16'b0, amt});
      plb_pkg::K_REMOVE: entry_down(c, {16'b0, amt});
      plb_pkg::K_SET:    tbl_run[c] = flg;
      default: begin
        d = now - tbl_last[c];
        if (n > 1 && d >= {16'b0, m_ival}) begin
          tbl_last[c] = now;
          busy = c;
          idle = c;
          hi = tbl_cnt[c];
          lo = tbl_cnt[c];
          // the current CPU seeds the search even when it is not running
          for (i = 0; i < n; i++) begin
            if (tbl_run[i]) begin
              if (tbl_cnt[i] > hi) begin
                hi = tbl_cnt[i];
                busy = i;
              end
              if (tbl_cnt[i] < lo) begin
                lo = tbl_cnt[i];
                idle = i;
              end
            end
          end
          if (m_mig && ({1'b0, hi} - {1'b0, lo}) > {1'b0, m_thr}) begin
            entry_down(busy, 32'd1);
            entry_up(idle, 32'd1);
            r.migrated = 1'b1;
            r.from_cpu = 3'(busy);
            r.to_cpu   = 3'(idle);
          end
        end
      end
    endcase
    sum  = 32'd0;
    minc = 32'hFFFF_FFFF;
    for (i = 0; i < n; i++) begin
      s   = {1'b0, sum} + {1'b0, tbl_load[i]};
      sum = s[32] ? 32'hFFFF_FFFF : s[31:0];
      if (tbl_run[i] && {16'b0, tbl_cnt[i]} < minc) begin
        minc           = {16'b0, tbl_cnt[i]};
        r.least_cpu    = 3'(i);
        r.idlest_valid = 1'b1;
      end
    end
    r.load_sum = sum;
    return r;
  endfunction

  function automatic plb_pkg::result_t mk_res(logic mig, logic [2:0] f, logic [2:0] t,
                                              logic [2:0] idl, logic v, logic [31:0] sum);
    plb_pkg::result_t r;
    r.migrated     = mig;
    r.from_cpu     = f;
    r.to_cpu       = t;
    r.least_cpu    = idl;
    r.idlest_valid = v;
    r.load_sum     = sum;
    return r;
  endfunction

  function automatic step_t op(plb_pkg::kind_t k, logic [2:0] c, logic [15:0] amt, logic flg,
                               logic [31:0] now);
    step_t s;
    s = '{default: '0};
    s.k   = k;
    s.c   = c;
    s.amt = amt;
    s.flg = flg;
    s.now = now;
    return s;
  endfunction

  function automatic step_t op_exp(plb_pkg::kind_t k, logic [2:0] c, logic [15:0] amt,
                                   logic flg, logic [31:0] now, plb_pkg::result_t w);
    step_t s;
    s = op(k, c, amt, flg, now);
    s.typed = 1'b1;
    s.want  = w;
    return s;
  endfunction

  function automatic step_t reg_wr(plb_pkg::cfg_idx_t idx, logic [15:0] v);
    step_t s;
    s = '{default: '0};
    s.is_cfg = 1'b1;
    s.ridx   = idx;
    s.rval   = v;
    return s;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int idle_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_item(plb_pkg::kind_t k, logic [2:0] c, logic [15:0] amt, logic flg,
                           logic [31:0] now, bit typed, plb_pkg::result_t want);
    int               gap;
    plb_pkg::result_t pred;
    gap = idle_gap();
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= k;
    in_tdata  <= {4'b0, now, flg, amt, c};
    do @(posedge clk); while (!in_tready);
    pred = predict_item(k, c, amt, flg, now);
    pending_res.push_back(typed ? want : pred);
  endtask

  // hold the sender until every outstanding result is back
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(plb_pkg::cfg_idx_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      plb_pkg::CFG_CPUS_PRESENT:  m_cpus = val[3:0];
      plb_pkg::CFG_BAL_INTERVAL:  m_ival = val;
      plb_pkg::CFG_IMB_THRESHOLD: m_thr  = val;
      default:                    m_mig  = val[0];
    endcase
  endtask

  task automatic flag_error(string what, plb_pkg::result_t want, plb_pkg::result_t got);
    fails++;
    if (shown < SHOW_MAX) begin
      shown++;
      $display("%0t %s: expected mig %0d from %0d to %0d least %0d/%0d sum %h", $time, what,
               want.migrated, want.from_cpu, want.to_cpu, want.least_cpu, want.idlest_valid,
               want.load_sum);
      $display("%0t %s: actual   mig %0d from %0d to %0d least %0d/%0d sum %h", $time, what,
               got.migrated, got.from_cpu, got.to_cpu, got.least_cpu, got.idlest_valid,
               got.load_sum);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    plb_pkg::result_t got;
    plb_pkg::result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = plb_pkg::result_t'(out_tdata[42:0]);
      if (pending_res.size() == 0) begin
        flag_error("unexpected result", '0, got);
      end else begin
        want = pending_res.pop_front();
        if (got.migrated !== want.migrated || got.from_cpu !== want.from_cpu ||
            got.to_cpu !== want.to_cpu || got.least_cpu !== want.least_cpu ||
            got.idlest_valid !== want.idlest_valid || got.load_sum !== want.load_sum)
          flag_error("mismatch", want, got);
      end
    end
  end

  // watchdog on cycles where neither channel moves an item
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // result side back-pressure
  initial begin
    int run;
    int gap;
    out_tready = 1'b0;
    forever begin
      run = $urandom_range(1, 8);
      repeat (run) begin
        @(negedge clk);
        out_tready <= 1'b1;
      end
      gap = idle_gap();
      repeat (gap) begin
        @(negedge clk);
        out_tready <= 1'b0;
      end
    end
  end

  initial begin
    int             p, j, r, n;
    plb_pkg::kind_t k;
    logic [2:0]     c;
    logic [15:0]    amt;
    logic           flg;
    logic [31:0]    now;
    logic [31:0]    tick_base;
    logic [3:0]     cpus;
    logic [15:0]    ival, thr;
    logic           mig;

    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    fails     = 0;
    shown     = 0;
    quiet     = 0;
    no_idle   = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      tbl_cnt[i]  = '0;
      tbl_load[i] = '0;
      tbl_last[i] = '0;
      tbl_run[i]  = 1'b0;
    end
    m_cpus = 4'd1;
    m_ival = 16'd100;
    m_thr  = 16'd2;
    m_mig  = 1'b1;

    // one CPU present after reset: ticks do nothing
    plan.push_back(op_exp(plb_pkg::K_ADD, 3'd0, 16'hFFFF, 1'b0, 32'd0,
                          mk_res(1'b0, 3'd0, 3'd0, 3'd0, 1'b0, 32'h0000_FFFF)));
    plan.push_back(op_exp(plb_pkg::K_TICK, 3'd0, 16'd0, 1'b1, 32'hFFFF_FFFF,
                          mk_res(1'b0, 3'd0, 3'd0, 3'd0, 1'b0, 32'h0000_FFFF)));
    plan.push_back(op_exp(plb_pkg::K_SET, 3'd0, 16'd0, 1'b1, 32'd0,
                          mk_res(1'b0, 3'd0, 3'd0, 3'd0, 1'b1, 32'h0000_FFFF)));
    plan.push_back(op_exp(plb_pkg::K_REMOVE, 3'd0, 16'hFFFF, 1'b0, 32'd0,
                          mk_res(1'b0, 3'd0, 3'd0, 3'd0, 1'b1, 32'd0)));
    // removal below zero floors
    plan.push_back(op_exp(plb_pkg::K_REMOVE, 3'd0, 16'd0, 1'b0, 32'd0,
                          mk_res(1'b0, 3'd0, 3'd0, 3'd0, 1'b1, 32'd0)));
    // target outside the present set still updates its entry
    plan.push_back(op_exp(plb_pkg::K_ADD, 3'd7, 16'd5, 1'b0, 32'd0,
                          mk_res(1'b0, 3'd0, 3'd0, 3'd0, 1'b1, 32'd0)));
    plan.push_back(reg_wr(plb_pkg::CFG_CPUS_PRESENT, 16'd0));
    plan.push_back(op_exp(plb_pkg::K_SET, 3'd1, 16'd0, 1'b1, 32'd0,
                          mk_res(1'b0, 3'd0, 3'd0, 3'd0, 1'b0, 32'd0)));
    plan.push_back(reg_wr(plb_pkg::CFG_CPUS_PRESENT, 16'd15));
    plan.push_back(reg_wr(plb_pkg::CFG_BAL_INTERVAL, 16'd0));
    plan.push_back(reg_wr(plb_pkg::CFG_IMB_THRESHOLD, 16'd0));
    plan.push_back(op(plb_pkg::K_SET, 3'd7, 16'd0, 1'b1, 32'd0));
    plan.push_back(op(plb_pkg::K_ADD, 3'd1, 16'd16, 1'b0, 32'd0));
    plan.push_back(op(plb_pkg::K_ADD, 3'd1, 16'd16, 1'b0, 32'd0));
    plan.push_back(op(plb_pkg::K_ADD, 3'd1, 16'd16, 1'b0, 32'd0));
    // current CPU not running, but seeds the search
    plan.push_back(op(plb_pkg::K_TICK, 3'd2, 16'd0, 1'b0, 32'd0));
    plan.push_back(reg_wr(plb_pkg::CFG_MIGRATE_ENABLE, 16'd0));
    plan.push_back(op(plb_pkg::K_TICK, 3'd1, 16'd0, 1'b0, 32'd1));
    plan.push_back(reg_wr(plb_pkg::CFG_MIGRATE_ENABLE, 16'd1));
    plan.push_back(reg_wr(plb_pkg::CFG_IMB_THRESHOLD, 16'hFFFF));
    plan.push_back(op(plb_pkg::K_TICK, 3'd3, 16'd0, 1'b0, 32'd2));
    plan.push_back(reg_wr(plb_pkg::CFG_IMB_THRESHOLD, 16'd0));
    plan.push_back(reg_wr(plb_pkg::CFG_BAL_INTERVAL, 16'hFFFF));
    plan.push_back(op(plb_pkg::K_TICK, 3'd0, 16'd0, 1'b0, 32'd5));
    plan.push_back(op(plb_pkg::K_TICK, 3'd0, 16'd0, 1'b0, 32'h0000_FFFF));
    plan.push_back(op(plb_pkg::K_SET, 3'd1, 16'd0, 1'b0, 32'd0));
    plan.push_back(reg_wr(plb_pkg::CFG_CPUS_PRESENT, 16'd3));
    plan.push_back(reg_wr(plb_pkg::CFG_BAL_INTERVAL, 16'd0));
    // current CPU outside the present set
    plan.push_back(op(plb_pkg::K_TICK, 3'd6, 16'd0, 1'b0, 32'h8000_0000));
    plan.push_back(op(plb_pkg::K_ADD, 3'd2, 16'd0, 1'b0, 32'd0));
    plan.push_back(op(plb_pkg::K_REMOVE, 3'd7, 16'hFFFF, 1'b0, 32'd0));
    plan.push_back(op(plb_pkg::K_SET, 3'd4, 16'd0, 1'b1, 32'd0));
    plan.push_back(reg_wr(plb_pkg::CFG_CPUS_PRESENT, 16'd2));
    plan.push_back(op(plb_pkg::K_TICK, 3'd0, 16'hFFFF, 1'b1, 32'hFFFF_FFFF));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain();
        cfg_write(plb_pkg::cfg_idx_t'(plan[i].ridx), plan[i].rval);
      end else begin
        send_item(plb_pkg::kind_t'(plan[i].k), plan[i].c, plan[i].amt, plan[i].flg,
                  plan[i].now, plan[i].typed, plan[i].want);
      end
    end

    tick_base = $urandom;
    for (p = 0; p < RAND_PHASES; p++) begin
      drain();
      cpus = 4'($urandom_range(2, 8));
      ival = 16'($urandom_range(0, 16));
      thr  = 16'($urandom_range(0, 3));
      mig  = ($urandom_range(0, 9) != 0);
      case (p)
        0: begin
          cpus = 4'd8;
          ival = 16'd0;
          thr  = 16'd0;
          mig  = 1'b1;
        end
        1: begin
          cpus = 4'd15;
          thr  = 16'd1;
        end
        2: begin
          cpus = 4'd2;
          thr  = 16'd0;
        end
        3: begin
          cpus = 4'($urandom_range(0, 15));
          ival = 16'hFFFF;
        end
        4: thr = 16'hFFFF;
        5: mig = 1'b0;
        default: ival = 16'($urandom);
      endcase
      cfg_write(plb_pkg::CFG_CPUS_PRESENT, {12'b0, cpus});
      cfg_write(plb_pkg::CFG_BAL_INTERVAL, ival);
      cfg_write(plb_pkg::CFG_IMB_THRESHOLD, thr);
      cfg_write(plb_pkg::CFG_MIGRATE_ENABLE, {15'b0, mig});
      no_idle = (p == 2 || p == 4);

      for (j = 0; j < PHASE_ITEMS; j++) begin
        if ($urandom_range(0, 99) == 0) drain();
        r = $urandom_range(0, 99);
        if (r < 35)      k = plb_pkg::K_ADD;
        else if (r < 50) k = plb_pkg::K_REMOVE;
        else if (r < 65) k = plb_pkg::K_SET;
        else             k = plb_pkg::K_TICK;
        n = cpus_taking_part();
        if (n > 0 && $urandom_range(0, 99) < 85) c = 3'($urandom_range(0, n - 1));
        else                                     c = 3'($urandom_range(0, 7));
        r = $urandom_range(0, 9);
        if (r == 0)      amt = 16'd0;
        else if (r == 1) amt = 16'hFFFF;
        else if (r < 6)  amt = 16'($urandom_range(0, 255));
        else             amt = 16'($urandom);
        flg = ($urandom_range(0, 99) < 75);
        tick_base = tick_base + 32'($urandom_range(0, 40));
        now = ($urandom_range(0, 19) == 0) ? 32'($urandom) : tick_base;
        send_item(k, c, amt, flg, now, 1'b0, '0);
      end
    end

    drain();
    repeat (40) @(posedge clk);
    fails = fails + pending_res.size();
    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/plb_pkg.sv
rtl/plb_table.sv
rtl/plb_ctrl.sv
rtl/per_cpu_load_balancer.sv
verif/per_cpu_load_balancer_tb.sv
